[rtl/lbc_pkg.sv]
// ----------------------------------------------------------------------------
// lbc_pkg
// Shared types and register codes of the Liang-Barsky line clipper.
// ----------------------------------------------------------------------------
package lbc_pkg;

   localparam int COORD_W = 16;
   localparam int DIFF_W  = 17;
   localparam int CSR_IDX_W = 3;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_WIN_LEFT   = 3'd0,
      CSR_WIN_BOTTOM = 3'd1,
      CSR_WIN_RIGHT  = 3'd2,
      CSR_WIN_TOP    = 3'd3
   } csr_index_type;

   // per-item data that rides alongside the dividers
   typedef struct packed {
      logic signed [COORD_W-1:0] x1;
      logic signed [COORD_W-1:0] y1;
      logic signed [DIFF_W-1:0]  dx;
      logic signed [DIFF_W-1:0]  dy;
      logic [3:0]                pzero;
      logic [3:0]                pneg;
      logic [3:0]                qneg;
   } side_type;

endpackage

[rtl/liang_barsky_line_clip.sv]
// ----------------------------------------------------------------------------
// liang_barsky_line_clip
// Clips line segments against a rectangular window with Liang-Barsky tests.
// ----------------------------------------------------------------------------
// Usage:
//   Input: drive req_start_x/y and req_end_x/y with start high; an item is
//   taken at every clock edge with start high, since busy stays low.
//   One item may enter every cycle.
//   Result: rsp_valid is high for one cycle with rsp_accepted and the
//   clipped endpoints; rejected segments give zero coordinates.
//   The divider pipeline yields one quotient bit per stage for each of the
//   four window edges. Throughput is one item per cycle.
//   Window registers are written through csr_valid/csr_ready (always ready),
//   index 0 left, 1 bottom, 2 right, 3 top; other indexes are ignored.
//   Write them only while no item is in flight.
//   Reset clears all valid bits and loads the window 0..1023 x 0..767.
//   The receiver cannot stall, so results leave in order without holding.
// ----------------------------------------------------------------------------
module liang_barsky_line_clip
   import lbc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      start,
   output logic                      busy,
   input  logic signed [COORD_W-1:0] req_start_x,
   input  logic signed [COORD_W-1:0] req_start_y,
   input  logic signed [COORD_W-1:0] req_end_x,
   input  logic signed [COORD_W-1:0] req_end_y,
   output logic                      rsp_valid,
   output logic                      rsp_accepted,
   output logic signed [COORD_W-1:0] rsp_clip_start_x,
   output logic signed [COORD_W-1:0] rsp_clip_start_y,
   output logic signed [COORD_W-1:0] rsp_clip_end_x,
   output logic signed [COORD_W-1:0] rsp_clip_end_y,
   input  logic                      csr_valid,
   output logic                      csr_ready,
   input  logic [CSR_IDX_W-1:0]      csr_index,
   input  logic [COORD_W-1:0]        csr_wdata
);
   localparam int DIV_LAT = FRAC_BITS + 5;
   localparam int RW      = FRAC_BITS + 3;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // window registers
   logic signed [COORD_W-1:0] left_ff, bottom_ff, right_ff, top_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff   <= 16'sd0;
         bottom_ff <= 16'sd0;
         right_ff  <= 16'sd1023;
         top_ff    <= 16'sd767;
      end else if (csr_valid) begin
         case (csr_index)
            CSR_WIN_LEFT:   left_ff   <= csr_wdata;
            CSR_WIN_BOTTOM: bottom_ff <= csr_wdata;
            CSR_WIN_RIGHT:  right_ff  <= csr_wdata;
            CSR_WIN_TOP:    top_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   // stage 1: capture the item
   logic                      v1_ff;
   logic signed [COORD_W-1:0] x1_ff, y1_ff, x2_ff, y2_ff;

   always_ff @(posedge clock) begin
      x1_ff <= req_start_x;
      y1_ff <= req_start_y;
      x2_ff <= req_end_x;
      y2_ff <= req_end_y;
   end

   // stage 2: deltas and edge distances
   logic                     v2_ff;
   logic signed [COORD_W-1:0] x1b_ff, y1b_ff;
   logic signed [DIFF_W-1:0] dx_ff, dy_ff;
   logic signed [DIFF_W-1:0] q_ff [0:3];

   always_ff @(posedge clock) begin
      x1b_ff  <= x1_ff;
      y1b_ff  <= y1_ff;
      dx_ff   <= DIFF_W'(x2_ff) - DIFF_W'(x1_ff);
      dy_ff   <= DIFF_W'(y2_ff) - DIFF_W'(y1_ff);
      q_ff[0] <= DIFF_W'(x1_ff) - DIFF_W'(left_ff);
      q_ff[1] <= DIFF_W'(right_ff) - DIFF_W'(x1_ff);
      q_ff[2] <= DIFF_W'(y1_ff) - DIFF_W'(bottom_ff);
      q_ff[3] <= DIFF_W'(top_ff) - DIFF_W'(y1_ff);
   end

   // stage 3: magnitudes and signs
   logic        v3_ff;
   logic [15:0] ap_ff [0:3];
   logic [15:0] aq_ff [0:3];
   logic        sgn_ff [0:3];
   side_type    side3_ff, side3_in;
   logic signed [DIFF_W-1:0] p_in [0:3];
   logic signed [DIFF_W-1:0] ap_w [0:3];
   logic signed [DIFF_W-1:0] aq_w [0:3];

   always_comb begin
      p_in[0] = -dx_ff;
      p_in[1] = dx_ff;
      p_in[2] = -dy_ff;
      p_in[3] = dy_ff;
      side3_in.x1 = x1b_ff;
      side3_in.y1 = y1b_ff;
      side3_in.dx = dx_ff;
      side3_in.dy = dy_ff;
      for (int e = 0; e < 4; e++) begin
         side3_in.pzero[e] = (p_in[e] == '0);
         side3_in.pneg[e]  = p_in[e][DIFF_W-1];
         side3_in.qneg[e]  = q_ff[e][DIFF_W-1];
         ap_w[e] = p_in[e][DIFF_W-1] ? -p_in[e] : p_in[e];
         aq_w[e] = q_ff[e][DIFF_W-1] ? -q_ff[e] : q_ff[e];
      end
   end

   always_ff @(posedge clock) begin
      side3_ff <= side3_in;
      for (int e = 0; e < 4; e++) begin
         ap_ff[e]  <= ap_w[e][15:0];
         aq_ff[e]  <= aq_w[e][15:0];
         sgn_ff[e] <= side3_in.pneg[e] ^ side3_in.qneg[e];
      end
   end

   // dividers, one per window edge
   logic signed [RW-1:0] ratio [0:3];

   for (genvar e = 0; e < 4; e++) begin : g_div
      lbc_div #(.FRAC_BITS(FRAC_BITS)) u_div (
         .clock (clock),
         .aq    (aq_ff[e]),
         .ap    (ap_ff[e]),
         .neg   (sgn_ff[e]),
         .ratio (ratio[e])
      );
   end

   // side data and valid travel with the divider
   side_type side_ff [0:DIV_LAT-1];
   logic     dv_ff   [0:DIV_LAT-1];

   always_ff @(posedge clock) begin
      side_ff[0] <= side3_ff;
      for (int k = 1; k < DIV_LAT; k++) begin
         side_ff[k] <= side_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         for (int k = 0; k < DIV_LAT; k++) begin
            dv_ff[k] <= 1'b0;
         end
      end else begin
         v1_ff    <= start;
         v2_ff    <= v1_ff;
         v3_ff    <= v2_ff;
         dv_ff[0] <= v3_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            dv_ff[k] <= dv_ff[k-1];
         end
      end
   end

   lbc_clip #(.FRAC_BITS(FRAC_BITS)) u_clip (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (dv_ff[DIV_LAT-1]),
      .side         (side_ff[DIV_LAT-1]),
      .r0           (ratio[0]),
      .r1           (ratio[1]),
      .r2           (ratio[2]),
      .r3           (ratio[3]),
      .out_valid    (rsp_valid),
      .accepted     (rsp_accepted),
      .clip_start_x (rsp_clip_start_x),
      .clip_start_y (rsp_clip_start_y),
      .clip_end_x   (rsp_clip_end_x),
      .clip_end_y   (rsp_clip_end_y)
   );

endmodule

[rtl/lbc_div.sv]
// ----------------------------------------------------------------------------
// lbc_div
// Pipelined restoring divider: (aq << FRAC_BITS) / ap, one quotient bit per
// stage, saturated to 2.0 and signed at the end.
// ----------------------------------------------------------------------------
module lbc_div #(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic [15:0]                 aq,
   input  logic [15:0]                 ap,
   input  logic                        neg,
   output logic signed [FRAC_BITS+2:0] ratio
);
   localparam int NSTEP = FRAC_BITS + 3;
   localparam int QW    = FRAC_BITS + 3;

   logic [15:0]   rem_ff [0:NSTEP];
   logic [15:0]   ap_ff  [0:NSTEP];
   logic [15:0]   aq_ff  [0:NSTEP];
   logic [QW-1:0] quo_ff [0:NSTEP];
   logic          ovf_ff [0:NSTEP];
   logic          neg_ff [0:NSTEP];
   logic signed [QW-1:0] ratio_ff;

   // quotient never reaches 2^(FRAC_BITS+3) unless aq >= 8*ap
   always_ff @(posedge clock) begin
      rem_ff[0] <= {3'b000, aq[15:3]};
      ovf_ff[0] <= ({3'b000, aq} >= {ap, 3'b000});
      ap_ff[0]  <= ap;
      aq_ff[0]  <= aq;
      neg_ff[0] <= neg;
      quo_ff[0] <= '0;
   end

   for (genvar k = 1; k <= NSTEP; k++) begin : g_step
      localparam int BIT = NSTEP - k;
      logic        nbit;
      logic [16:0] sh;
      logic        ge;
      logic [16:0] diff;
      if (BIT >= FRAC_BITS) begin : g_num
         assign nbit = aq_ff[k-1][BIT-FRAC_BITS];
      end else begin : g_zero
         assign nbit = 1'b0;
      end
      assign sh   = {rem_ff[k-1], nbit};
      assign ge   = (sh >= {1'b0, ap_ff[k-1]});
      assign diff = sh - {1'b0, ap_ff[k-1]};
      always_ff @(posedge clock) begin
         rem_ff[k] <= ge ? diff[15:0] : sh[15:0];
         quo_ff[k] <= {quo_ff[k-1][QW-2:0], ge};
         ap_ff[k]  <= ap_ff[k-1];
         aq_ff[k]  <= aq_ff[k-1];
         ovf_ff[k] <= ovf_ff[k-1];
         neg_ff[k] <= neg_ff[k-1];
      end
   end

   localparam logic [QW-1:0] LIM = QW'(1) << (FRAC_BITS + 1);

   logic [QW-1:0] mag;
   always_comb begin
      mag = quo_ff[NSTEP];
      if (ovf_ff[NSTEP] || (quo_ff[NSTEP] > LIM)) begin
         mag = LIM;
      end
   end

   always_ff @(posedge clock) begin
      ratio_ff <= neg_ff[NSTEP] ? -$signed(mag) : $signed(mag);
   end

   assign ratio = ratio_ff;

endmodule

[rtl/lbc_clip.sv]
// ----------------------------------------------------------------------------
// lbc_clip
// Edge decisions on the four ratios, then interpolation of the endpoints.
// ----------------------------------------------------------------------------
module lbc_clip
   import lbc_pkg::*;
#(
   parameter int FRAC_BITS = 16
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        in_valid,
   input  side_type                    side,
   input  logic signed [FRAC_BITS+2:0] r0,
   input  logic signed [FRAC_BITS+2:0] r1,
   input  logic signed [FRAC_BITS+2:0] r2,
   input  logic signed [FRAC_BITS+2:0] r3,
   output logic                        out_valid,
   output logic                        accepted,
   output logic signed [COORD_W-1:0]   clip_start_x,
   output logic signed [COORD_W-1:0]   clip_start_y,
   output logic signed [COORD_W-1:0]   clip_end_x,
   output logic signed [COORD_W-1:0]   clip_end_y
);
   localparam int RW = FRAC_BITS + 3;
   localparam int UW = FRAC_BITS + 1;
   localparam int PW = FRAC_BITS + 19;

   typedef struct packed {
      logic          ok;
      logic [UW-1:0] u0;
      logic [UW-1:0] u1;
   } edge_res_type;

   function automatic edge_res_type edge_step(input logic pz, input logic pn,
                                              input logic qn,
                                              input logic signed [RW-1:0] r,
                                              input edge_res_type cur);
      edge_res_type res;
      res = cur;
      if (cur.ok) begin
         if (pz) begin
            res.ok = !qn;
         end else if (pn) begin
            if (r > $signed({2'b00, cur.u1})) begin
               res.ok = 1'b0;
            end else if (r > $signed({2'b00, cur.u0})) begin
               res.u0 = r[UW-1:0];
            end
         end else begin
            if (r < $signed({2'b00, cur.u0})) begin
               res.ok = 1'b0;
            end else if (r < $signed({2'b00, cur.u1})) begin
               res.u1 = r[UW-1:0];
            end
         end
      end
      return res;
   endfunction

   // stage 1: left and right edges
   edge_res_type        e1_ff, e1_in, e0;
   side_type            s1_ff;
   logic signed [RW-1:0] r2_ff, r3_ff;
   logic                v1_ff;

   always_comb begin
      e0.ok = 1'b1;
      e0.u0 = '0;
      e0.u1 = UW'(1) << FRAC_BITS;
      e1_in = edge_step(side.pzero[1], side.pneg[1], side.qneg[1], r1,
                        edge_step(side.pzero[0], side.pneg[0], side.qneg[0], r0, e0));
   end

   always_ff @(posedge clock) begin
      e1_ff <= e1_in;
      s1_ff <= side;
      r2_ff <= r2;
      r3_ff <= r3;
   end

   // stage 2: bottom and top edges
   edge_res_type e2_ff, e2_in;
   side_type     s2_ff;
   logic         v2_ff;

   assign e2_in = edge_step(s1_ff.pzero[3], s1_ff.pneg[3], s1_ff.qneg[3], r3_ff,
                            edge_step(s1_ff.pzero[2], s1_ff.pneg[2], s1_ff.qneg[2],
                                      r2_ff, e1_ff));

   always_ff @(posedge clock) begin
      e2_ff <= e2_in;
      s2_ff <= s1_ff;
   end

   // stage 3: products
   logic signed [PW-1:0] m0x_ff, m0y_ff, m1x_ff, m1y_ff;
   logic                 ok3_ff;
   logic signed [COORD_W-1:0] x3_ff, y3_ff;
   logic                 v3_ff;

   always_ff @(posedge clock) begin
      m0x_ff <= PW'($signed({1'b0, e2_ff.u0}) * s2_ff.dx);
      m0y_ff <= PW'($signed({1'b0, e2_ff.u0}) * s2_ff.dy);
      m1x_ff <= PW'($signed({1'b0, e2_ff.u1}) * s2_ff.dx);
      m1y_ff <= PW'($signed({1'b0, e2_ff.u1}) * s2_ff.dy);
      ok3_ff <= e2_ff.ok;
      x3_ff  <= s2_ff.x1;
      y3_ff  <= s2_ff.y1;
   end

   // stage 4: round, offset, zero on reject
   localparam logic signed [PW-1:0] HALF = PW'(1) << (FRAC_BITS - 1);

   function automatic logic [COORD_W-1:0] interp(input logic signed [PW-1:0] m,
                                                 input logic signed [COORD_W-1:0] s);
      logic signed [PW-1:0] sh;
      sh = (m + HALF) >>> FRAC_BITS;
      return sh[COORD_W-1:0] + s;
   endfunction

   logic                      v4_ff, acc_ff;
   logic signed [COORD_W-1:0] sx_ff, sy_ff, ex_ff, ey_ff;

   always_ff @(posedge clock) begin
      acc_ff <= ok3_ff;
      sx_ff  <= ok3_ff ? interp(m0x_ff, x3_ff) : '0;
      sy_ff  <= ok3_ff ? interp(m0y_ff, y3_ff) : '0;
      ex_ff  <= ok3_ff ? interp(m1x_ff, x3_ff) : '0;
      ey_ff  <= ok3_ff ? interp(m1y_ff, y3_ff) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
         v3_ff <= 1'b0;
         v4_ff <= 1'b0;
      end else begin
         v1_ff <= in_valid;
         v2_ff <= v1_ff;
         v3_ff <= v2_ff;
         v4_ff <= v3_ff;
      end
   end

   assign out_valid    = v4_ff;
   assign accepted     = acc_ff;
   assign clip_start_x = sx_ff;
   assign clip_start_y = sy_ff;
   assign clip_end_x   = ex_ff;
   assign clip_end_y   = ey_ff;

endmodule

[bench/liang_barsky_line_clip_test.sv]
// ----------------------------------------------------------------------------
// liang_barsky_line_clip_test
// Drives segments through the clipper under several windows, random start
// gaps and random window writes between phases, and compares every result
// with a fixed expected result or a fixed-point clipping predictor kept in the bench.
// ----------------------------------------------------------------------------
module liang_barsky_line_clip_test;
   import lbc_pkg::*;

   timeunit 1ns;
   timeprecision 1ps;

   localparam int FRAC = 16;
   localparam int LATENCY = FRAC + 12;
   localparam int IDLE_LIMIT = 2000;
   localparam int RANDOM_ITEMS = 1880;

   typedef logic signed [15:0] coord_type;

   typedef struct packed {
      logic      accepted;
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
   } clip_type;

   typedef struct packed {
      coord_type sx;
      coord_type sy;
      coord_type ex;
      coord_type ey;
      logic      check_fixed;
      clip_type  fixed_result;
   } segment_row_type;

   logic      clock = 1'b0;
   logic      reset = 1'b1;
   logic      start = 1'b0;
   logic      busy;
   coord_type req_start_x = '0;
   coord_type req_start_y = '0;
   coord_type req_end_x = '0;
   coord_type req_end_y = '0;
   logic      rsp_valid;
   logic      rsp_accepted;
   coord_type rsp_clip_start_x;
   coord_type rsp_clip_start_y;
   coord_type rsp_clip_end_x;
   coord_type rsp_clip_end_y;
   logic      csr_valid = 1'b0;
   logic      csr_ready;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0] csr_wdata = '0;

   // window copy: left, bottom, right, top
   coord_type win [4];
   clip_type  pending_clips [$];
   logic      failed = 1'b0;
   int        idle_cycles = 0;

   always #2 clock = ~clock;

   liang_barsky_line_clip i_dut (.*);

   function automatic longint ratio_fx(longint q, longint p);
      longint aq;
      longint ap;
      longint quo;
      aq = (q < 0) ? -q : q;
      ap = (p < 0) ? -p : p;
      quo = (aq <<< FRAC) / ap;
      if (quo > (64'sd1 <<< (FRAC + 1)))
         quo = 64'sd1 <<< (FRAC + 1);
      return ((q < 0) != (p < 0)) ? -quo : quo;
   endfunction

   function automatic logic edge_pass(longint p, longint q, inout longint u0,
                                      inout longint u1);
      longint r;
      if (p == 0)
         return q >= 0;
      r = ratio_fx(q, p);
      if (p < 0) begin
         if (r > u1)
            return 1'b0;
         if (r > u0)
            u0 = r;
      end else begin
         if (r < u0)
            return 1'b0;
         if (r < u1)
            u1 = r;
      end
      return 1'b1;
   endfunction

   // floor shift after adding one half
   function automatic longint round_fx(longint v);
      return (v + (64'sd1 <<< (FRAC - 1))) >>> FRAC;
   endfunction

   function automatic clip_type clip_segment(coord_type sx, coord_type sy, coord_type ex,
                                             coord_type ey);
      longint   dx;
      longint   dy;
      longint   u0;
      longint   u1;
      logic     visible;
      clip_type c;
      dx = longint'(ex) - longint'(sx);
      dy = longint'(ey) - longint'(sy);
      u0 = 0;
      u1 = 64'sd1 <<< FRAC;
      visible = edge_pass(-dx, longint'(sx) - longint'(win[CSR_WIN_LEFT]), u0, u1);
      if (visible)
         visible = edge_pass(dx, longint'(win[CSR_WIN_RIGHT]) - longint'(sx), u0, u1);
      if (visible)
         visible = edge_pass(-dy, longint'(sy) - longint'(win[CSR_WIN_BOTTOM]), u0, u1);
      if (visible)
         visible = edge_pass(dy, longint'(win[CSR_WIN_TOP]) - longint'(sy), u0, u1);
      c = '0;
      if (visible) begin
         c.accepted = 1'b1;
         c.sx = coord_type'(longint'(sx) + round_fx(u0 * dx));
         c.sy = coord_type'(longint'(sy) + round_fx(u0 * dy));
         c.ex = coord_type'(longint'(sx) + round_fx(u1 * dx));
         c.ey = coord_type'(longint'(sy) + round_fx(u1 * dy));
      end
      return c;
   endfunction

   // check each result against the oldest expectation
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         clip_type want;
         if (pending_clips.size() == 0) begin
            $error("unexpected result");
            failed = 1'b1;
         end else begin
            want = pending_clips.pop_front();
            if (rsp_accepted !== want.accepted) begin
               $error("accepted: expected %0d actual %0d", want.accepted, rsp_accepted);
               failed = 1'b1;
            end
            if (rsp_clip_start_x !== want.sx) begin
               $error("clip_start_x: expected %0d actual %0d", want.sx, rsp_clip_start_x);
               failed = 1'b1;
            end
            if (rsp_clip_start_y !== want.sy) begin
               $error("clip_start_y: expected %0d actual %0d", want.sy, rsp_clip_start_y);
               failed = 1'b1;
            end
            if (rsp_clip_end_x !== want.ex) begin
               $error("clip_end_x: expected %0d actual %0d", want.ex, rsp_clip_end_x);
               failed = 1'b1;
            end
            if (rsp_clip_end_y !== want.ey) begin
               $error("clip_end_y: expected %0d actual %0d", want.ey, rsp_clip_end_y);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog on cycles with no handshake
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid || (csr_valid && csr_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
         $display("liang_barsky_line_clip: mismatch");
         $finish;
      end
   end

   // present one write and hold valid; the caller drops it after the last one
   task automatic write_window(csr_index_type idx, coord_type value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      while (!csr_ready)
         @(posedge clock);
      win[idx] = value;
   endtask

   task automatic set_window(coord_type l, coord_type b, coord_type r, coord_type t);
      write_window(CSR_WIN_LEFT, l);
      write_window(CSR_WIN_BOTTOM, b);
      write_window(CSR_WIN_RIGHT, r);
      write_window(CSR_WIN_TOP, t);
      csr_valid <= 1'b0;
   endtask

   // wait out gap, then present one item; start stays high across back-to-back items
   task automatic send_segment(coord_type sx, coord_type sy, coord_type ex, coord_type ey,
                               logic check_fixed, clip_type fixed_result);
      int gap;
      clip_type want;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_start_x <= sx;
      req_start_y <= sy;
      req_end_x <= ex;
      req_end_y <= ey;
      @(posedge clock);
      while (busy)
         @(posedge clock);
      want = check_fixed ? fixed_result : clip_segment(sx, sy, ex, ey);
      pending_clips.push_back(want);
   endtask

   task automatic drain;
      start <= 1'b0;
      while (pending_clips.size() != 0)
         @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic coord_type near_coord(coord_type lo, coord_type hi);
      int span;
      span = (int'(hi) - int'(lo));
      if (span < 0)
         span = -span;
      return coord_type'(int'(lo) - 64 + int'($urandom_range(0, span + 128)));
   endfunction

   segment_row_type directed_rows [] = '{
      '{0, 0, 1023, 767, 1'b1, '{1'b1, 16'sd0, 16'sd0, 16'sd1023, 16'sd767}},
      '{100, 100, 100, 100, 1'b1, '{1'b1, 16'sd100, 16'sd100, 16'sd100, 16'sd100}},
      '{-5, 10, -5, 10, 1'b1, '0},
      '{1023, 767, 1023, 767, 1'b1, '{1'b1, 16'sd1023, 16'sd767, 16'sd1023, 16'sd767}},
      '{2000, 10, 3000, 20, 1'b1, '0},
      '{-100, 10, -50, 20, 1'b1, '0},
      '{10, -100, 20, -200, 1'b1, '0},
      '{10, 800, 20, 900, 1'b1, '0},
      '{-32768, -32768, 32767, 32767, 1'b0, '0},
      '{32767, 32767, -32768, -32768, 1'b0, '0},
      '{-32768, 300, 32767, 300, 1'b0, '0},
      '{500, 32767, 500, -32768, 1'b0, '0},
      '{-100, -100, 2000, 2000, 1'b0, '0},
      '{-10, 400, 500, 400, 1'b0, '0},
      '{500, 400, 1100, 900, 1'b0, '0},
      '{-1, 0, 1, 0, 1'b0, '0},
      '{32767, 0, -32768, 0, 1'b0, '0},
      '{3, 5, 1020, 760, 1'b0, '0},
      '{-32768, -32768, -32768, -32768, 1'b1, '0},
      '{1023, 0, 1024, 1, 1'b0, '0}
   };

   initial begin
      coord_type l, b, r, t;
      int phase_items;
      int total;
      win[CSR_WIN_LEFT] = 0;
      win[CSR_WIN_BOTTOM] = 0;
      win[CSR_WIN_RIGHT] = 1023;
      win[CSR_WIN_TOP] = 767;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // reset window first
      foreach (directed_rows[k])
         send_segment(directed_rows[k].sx, directed_rows[k].sy, directed_rows[k].ex,
                      directed_rows[k].ey, directed_rows[k].check_fixed,
                      directed_rows[k].fixed_result);
      drain();

      // whole coordinate range, then an inverted window
      set_window(-32768, -32768, 32767, 32767);
      send_segment(-32768, -32768, 32767, 32767, 1'b1,
                   '{1'b1, 16'sh8000, 16'sh8000, 16'sd32767, 16'sd32767});
      send_segment(32767, -32768, -32768, 32767, 1'b0, '0);
      drain();
      set_window(500, 500, 100, 100);
      send_segment(300, 300, 300, 300, 1'b1, '0);
      send_segment(0, 0, 600, 600, 1'b1, '0);
      drain();

      total = 0;
      while (total < RANDOM_ITEMS) begin
         case ($urandom_range(0, 5))
            0: begin
               l = coord_type'($urandom);
               b = coord_type'($urandom);
               r = coord_type'($urandom);
               t = coord_type'($urandom);
            end
            1: begin
               l = coord_type'(-32768);
               b = coord_type'(-32768);
               r = coord_type'(32767);
               t = coord_type'(32767);
            end
            default: begin
               l = coord_type'(int'($urandom_range(0, 2000)) - 1000);
               b = coord_type'(int'($urandom_range(0, 2000)) - 1000);
               r = l + coord_type'($urandom_range(0, 1500));
               t = b + coord_type'($urandom_range(0, 1500));
            end
         endcase
         set_window(l, b, r, t);
         phase_items = $urandom_range(50, 200);
         if (phase_items > RANDOM_ITEMS - total)
            phase_items = RANDOM_ITEMS - total;
         repeat (phase_items) begin
            if ($urandom_range(0, 4) == 0)
               send_segment(coord_type'($urandom), coord_type'($urandom),
                            coord_type'($urandom), coord_type'($urandom), 1'b0, '0);
            else
               send_segment(near_coord(l, r), near_coord(b, t), near_coord(l, r),
                            near_coord(b, t), 1'b0, '0);
         end
         total += phase_items;
         drain();
      end

      repeat (LATENCY + 8) @(posedge clock);
      if (!failed && pending_clips.size() == 0)
         $display("liang_barsky_line_clip: match");
      else
         $display("liang_barsky_line_clip: mismatch");
      $finish;
   end

endmodule
